@@ src/pmo_pkg.sv @@
// ----------------------------------------------------------------------------
// pmo_pkg
// Shared types and constants of the polygon margin offset block: datapath
// operation codes, controller states, corner and unit selects, and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package pmo_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int MARGIN_W        = 31;
	localparam int PDATA_W         = 32;
	localparam int PADDR_W         = 3;

	localparam logic       REG_MARGIN = 1'b0;
	localparam logic [1:0] CNT_FULL   = 2'd3;
	localparam logic [1:0] CNT_TWO    = 2'd2;

	typedef enum logic [1:0] {
		CRN_OPEN,
		CRN_WRAP,
		CRN_CLOSE
	} pmo_corner_t;

	typedef enum logic [1:0] {
		UNIT_J,
		UNIT_K,
		UNIT_W
	} pmo_unit_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_SHIFT,
		OP_ULOAD,
		OP_NORM,
		OP_SQ0,
		OP_SQ1,
		OP_SQRT_GO,
		OP_SQRT,
		OP_DIVX_GO,
		OP_DIVY_GO,
		OP_DIV,
		OP_USTORE,
		OP_DOT0,
		OP_DOT1,
		OP_CROSS0,
		OP_CROSS1,
		OP_NUM0,
		OP_NUM1,
		OP_MD0,
		OP_MD1,
		OP_MD2,
		OP_MD_GO,
		OP_RES,
		OP_EMIT
	} pmo_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_TOOFEW,
		ST_ULOAD,
		ST_NORM,
		ST_SQ0,
		ST_SQ1,
		ST_SQRT_GO,
		ST_SQRT,
		ST_DIVX_GO,
		ST_DIVX,
		ST_DIVY_GO,
		ST_DIVY,
		ST_USTORE,
		ST_DOT0,
		ST_DOT1,
		ST_CROSS0,
		ST_CROSS1,
		ST_SCHK,
		ST_NUM0,
		ST_NUM1,
		ST_MD0,
		ST_MD1,
		ST_MD2,
		ST_MD_GO,
		ST_MDDIV,
		ST_RES,
		ST_EMIT,
		ST_DEG0,
		ST_DEG1,
		ST_SHIFT
	} pmo_state_t;

	typedef struct packed {
		pmo_op_t     op;
		pmo_corner_t corner;
		pmo_unit_t   unit;
		logic        pt;
		logic        axis;
		logic [1:0]  cnt;
		logic        deg;
		logic        last;
	} pmo_cmd_t;

	typedef struct packed {
		logic unit_zero;
		logic norm_done;
		logic sqrt_done;
		logic div_done;
		logic s_zero;
		logic out_free;
	} pmo_sts_t;

endpackage

@@ src/pmo_ctrl.sv @@
// ----------------------------------------------------------------------------
// pmo_ctrl
// Sequencer of the margin offset: steps each corner through three unit
// vectors, two offset points and their emission, and keeps the vertex count.
// ----------------------------------------------------------------------------
module pmo_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             last_vertex,
	output logic             in_stall,
	input  pmo_pkg::pmo_sts_t sts,
	output pmo_pkg::pmo_cmd_t cmd
);
	import pmo_pkg::*;

	pmo_state_t  state_q, state_d;
	pmo_corner_t corner_q, corner_d;
	pmo_unit_t   unit_q, unit_d;
	logic        pt_q, pt_d;
	logic        axis_q, axis_d;
	logic        pdeg_q, pdeg_d;
	logic        last_q, last_d;
	logic [1:0]  cnt_q, cnt_d;
	logic        close_last;

	assign in_stall   = (state_q != ST_IDLE);
	assign close_last = last_q && (corner_q == CRN_CLOSE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			corner_q <= CRN_OPEN;
			unit_q   <= UNIT_J;
			pt_q     <= 1'b0;
			axis_q   <= 1'b0;
			pdeg_q   <= 1'b0;
			last_q   <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			state_q  <= state_d;
			corner_q <= corner_d;
			unit_q   <= unit_d;
			pt_q     <= pt_d;
			axis_q   <= axis_d;
			pdeg_q   <= pdeg_d;
			last_q   <= last_d;
			cnt_q    <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		corner_d = corner_q;
		unit_d   = unit_q;
		pt_d     = pt_q;
		axis_d   = axis_q;
		pdeg_d   = pdeg_q;
		last_d   = last_q;
		cnt_d    = cnt_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) begin
				last_d   = last_vertex;
				corner_d = CRN_OPEN;
				unit_d   = UNIT_J;
				if (last_vertex && cnt_q < CNT_TWO) state_d = ST_TOOFEW;
				else if (cnt_q < CNT_TWO)          state_d = ST_SHIFT;
				else                               state_d = ST_ULOAD;
			end
			ST_TOOFEW: if (sts.out_free) begin
				cnt_d   = 2'd0;
				state_d = ST_IDLE;
			end
			ST_ULOAD: state_d = ST_NORM;
			ST_NORM: begin
				if (sts.unit_zero)      state_d = ST_DEG0;
				else if (sts.norm_done) state_d = ST_SQ0;
			end
			ST_SQ0:     state_d = ST_SQ1;
			ST_SQ1:     state_d = ST_SQRT_GO;
			ST_SQRT_GO: state_d = ST_SQRT;
			ST_SQRT:    if (sts.sqrt_done) state_d = ST_DIVX_GO;
			ST_DIVX_GO: state_d = ST_DIVX;
			ST_DIVX:    if (sts.div_done) state_d = ST_DIVY_GO;
			ST_DIVY_GO: state_d = ST_DIVY;
			ST_DIVY:    if (sts.div_done) state_d = ST_USTORE;
			ST_USTORE: begin
				if (unit_q == UNIT_W) begin
					pt_d    = 1'b0;
					state_d = ST_DOT0;
				end else begin
					unit_d  = (unit_q == UNIT_J) ? UNIT_K : UNIT_W;
					state_d = ST_ULOAD;
				end
			end
			ST_DOT0:   state_d = ST_DOT1;
			ST_DOT1:   state_d = ST_CROSS0;
			ST_CROSS0: state_d = ST_CROSS1;
			ST_CROSS1: state_d = ST_SCHK;
			ST_SCHK: begin
				if (sts.s_zero) begin
					pdeg_d  = 1'b1;
					state_d = ST_EMIT;
				end else begin
					pdeg_d  = 1'b0;
					axis_d  = 1'b0;
					state_d = ST_NUM0;
				end
			end
			ST_NUM0:  state_d = ST_NUM1;
			ST_NUM1:  state_d = ST_MD0;
			ST_MD0:   state_d = ST_MD1;
			ST_MD1:   state_d = ST_MD2;
			ST_MD2:   state_d = ST_MD_GO;
			ST_MD_GO: state_d = ST_MDDIV;
			ST_MDDIV: if (sts.div_done) state_d = ST_RES;
			ST_RES: begin
				if (!axis_q) begin
					axis_d  = 1'b1;
					state_d = ST_NUM0;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT, ST_DEG1: if (sts.out_free) begin
				if (state_q == ST_EMIT && !pt_q) begin
					pt_d    = 1'b1;
					state_d = ST_DOT0;
				end else if (last_q && corner_q == CRN_OPEN) begin
					corner_d = CRN_WRAP;
					unit_d   = UNIT_J;
					state_d  = ST_ULOAD;
				end else if (corner_q == CRN_WRAP) begin
					corner_d = CRN_CLOSE;
					unit_d   = UNIT_J;
					state_d  = ST_ULOAD;
				end else begin
					state_d = ST_SHIFT;
				end
			end
			ST_DEG0: if (sts.out_free) state_d = ST_DEG1;
			ST_SHIFT: begin
				if (last_q)                cnt_d = 2'd0;
				else if (cnt_q != CNT_FULL) cnt_d = cnt_q + 2'd1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op     = OP_NONE;
		cmd.corner = corner_q;
		cmd.unit   = unit_q;
		cmd.pt     = pt_q;
		cmd.axis   = axis_q;
		cmd.cnt    = cnt_q;
		cmd.deg    = 1'b0;
		cmd.last   = 1'b0;
		unique case (state_q)
			ST_IDLE:    if (in_valid) cmd.op = OP_ACCEPT;
			ST_TOOFEW: if (sts.out_free) begin
				cmd.op   = OP_EMIT;
				cmd.deg  = 1'b1;
				cmd.last = 1'b1;
			end
			ST_ULOAD:   cmd.op = OP_ULOAD;
			ST_NORM:    if (!sts.unit_zero && !sts.norm_done) cmd.op = OP_NORM;
			ST_SQ0:     cmd.op = OP_SQ0;
			ST_SQ1:     cmd.op = OP_SQ1;
			ST_SQRT_GO: cmd.op = OP_SQRT_GO;
			ST_SQRT:    if (!sts.sqrt_done) cmd.op = OP_SQRT;
			ST_DIVX_GO: cmd.op = OP_DIVX_GO;
			ST_DIVX, ST_DIVY, ST_MDDIV: if (!sts.div_done) cmd.op = OP_DIV;
			ST_DIVY_GO: cmd.op = OP_DIVY_GO;
			ST_USTORE:  cmd.op = OP_USTORE;
			ST_DOT0:    cmd.op = OP_DOT0;
			ST_DOT1:    cmd.op = OP_DOT1;
			ST_CROSS0:  cmd.op = OP_CROSS0;
			ST_CROSS1:  cmd.op = OP_CROSS1;
			ST_SCHK:    cmd.op = OP_NONE;
			ST_NUM0:    cmd.op = OP_NUM0;
			ST_NUM1:    cmd.op = OP_NUM1;
			ST_MD0:     cmd.op = OP_MD0;
			ST_MD1:     cmd.op = OP_MD1;
			ST_MD2:     cmd.op = OP_MD2;
			ST_MD_GO:   cmd.op = OP_MD_GO;
			ST_RES:     cmd.op = OP_RES;
			ST_EMIT: if (sts.out_free) begin
				cmd.op   = OP_EMIT;
				cmd.deg  = pdeg_q;
				cmd.last = pt_q && close_last;
			end
			ST_DEG0: if (sts.out_free) begin
				cmd.op  = OP_EMIT;
				cmd.deg = 1'b1;
			end
			ST_DEG1: if (sts.out_free) begin
				cmd.op   = OP_EMIT;
				cmd.deg  = 1'b1;
				cmd.last = close_last;
			end
			ST_SHIFT:   cmd.op = OP_SHIFT;
			default:    cmd.op = OP_NONE;
		endcase
	end

`ifndef SYNTH
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_EMIT |-> sts.out_free)
		else $error("result loaded while output slot is held");
	a_toofew: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE && in_valid && last_vertex && cnt_q < CNT_TWO
		|=> state_q == ST_TOOFEW)
		else $error("short polygon not flagged");
	a_zero_unit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_NORM && sts.unit_zero |=> state_q == ST_DEG0)
		else $error("zero vector not routed to degenerate corner");
	a_shift_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SHIFT |=> state_q == ST_IDLE && in_stall == 1'b0)
		else $error("vertex update does not return to idle");
`endif

endmodule

@@ src/pmo_dpath.sv @@
// ----------------------------------------------------------------------------
// pmo_dpath
// Datapath of the margin offset: vertex stores, normalizer, shared
// multiplier, bit-per-cycle square root and divider, output register.
// ----------------------------------------------------------------------------
module pmo_dpath #(
	parameter int COORD_WIDTH = pmo_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pmo_pkg::pmo_cmd_t             cmd,
	output pmo_pkg::pmo_sts_t             sts,
	input  logic signed [COORD_WIDTH-1:0] vertex_x,
	input  logic signed [COORD_WIDTH-1:0] vertex_y,
	input  logic [pmo_pkg::MARGIN_W-1:0]  margin,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0] point_x,
	output logic signed [COORD_WIDTH-1:0] point_y,
	output logic                          degenerate,
	output logic                          last_point
);
	import pmo_pkg::*;

	localparam int MW = (COORD_WIDTH + 1 > 32) ? COORD_WIDTH + 1 : 32;
	localparam int EW = MW + 1;
	localparam logic [6:0] DIV_UNIT_STEPS = 7'd62;
	localparam logic [6:0] DIV_MD_STEPS   = 7'd96;
	localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
	localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
	localparam logic [95:0] Q_CAP = 96'd1 << 62;
	localparam logic signed [33:0] UNIT_ONE = 34'sd1073741824;

	function automatic logic signed [32:0] trunc30(input logic signed [63:0] v);
		logic signed [63:0] a;
		logic signed [63:0] t;
		begin
			a = v[63] ? -v : v;
			t = a >>> 30;
			trunc30 = v[63] ? -33'(t) : 33'(t);
		end
	endfunction

	logic signed [COORD_WIDTH-1:0] vert_x_q, vert_y_q, first_x_q, first_y_q;
	logic signed [COORD_WIDTH-1:0] second_x_q, second_y_q, older_x_q, older_y_q;
	logic signed [COORD_WIDTH-1:0] newer_x_q, newer_y_q;
	logic signed [COORD_WIDTH-1:0] a_x, a_y, b_x, b_y, c_x, c_y, b_ax;
	logic signed [EW-1:0] ex, ey, fx, fy, ux_in, uy_in;
	logic [MW-1:0] mx_q, my_q, big;
	logic sx_q, sy_q, zero_q;
	logic norm_hi, norm_lo;
	logic [63:0] sq_q, sr_n_q, sr_r_q, sr_bit_q, sr_sum;
	logic [31:0] len;
	logic [61:0] udvd_x, udvd_y;
	logic [64:0] dv_rem_q, rem_sh, rem_nx;
	logic [95:0] dv_num_q, dv_quo_q, md_q;
	logic [63:0] dv_den_q, den_md;
	logic [6:0] dv_cnt_q;
	logic rem_ge;
	logic signed [31:0] jx_q, jy_q, kx_q, ky_q, wx_q, wy_q, n_x, n_y, uval;
	logic signed [33:0] mul_a, mul_b, om;
	logic signed [67:0] mul_p;
	logic signed [63:0] prod_s, dot_q, num_q, uoff, sum;
	logic signed [32:0] c_q, s_q;
	logic [32:0] s_mag;
	logic [62:0] num_mag, qs;
	logic signed [COORD_WIDTH-1:0] res_x_q, res_y_q, res_val;
	logic out_valid_q, out_deg_q, out_last_q;
	logic signed [COORD_WIDTH-1:0] out_x_q, out_y_q;

	always_comb begin
		unique case (cmd.corner)
			CRN_OPEN: begin
				a_x = older_x_q; a_y = older_y_q;
				b_x = newer_x_q; b_y = newer_y_q;
				c_x = vert_x_q;  c_y = vert_y_q;
			end
			CRN_WRAP: begin
				a_x = newer_x_q; a_y = newer_y_q;
				b_x = vert_x_q;  b_y = vert_y_q;
				c_x = first_x_q; c_y = first_y_q;
			end
			default: begin
				a_x = vert_x_q;   a_y = vert_y_q;
				b_x = first_x_q;  b_y = first_y_q;
				c_x = second_x_q; c_y = second_y_q;
			end
		endcase
	end

	assign ex = EW'(b_x) - EW'(a_x);
	assign ey = EW'(b_y) - EW'(a_y);
	assign fx = EW'(c_x) - EW'(b_x);
	assign fy = EW'(c_y) - EW'(b_y);

	always_comb begin
		unique case (cmd.unit)
			UNIT_J:  begin ux_in = -ey; uy_in = ex; end
			UNIT_K:  begin ux_in = -fy; uy_in = fx; end
			default: begin
				ux_in = EW'(jx_q) + EW'(kx_q);
				uy_in = EW'(jy_q) + EW'(ky_q);
			end
		endcase
	end

	assign big     = (mx_q > my_q) ? mx_q : my_q;
	assign norm_hi = |big[MW-1:31];
	assign norm_lo = ~|big[MW-1:30];

	assign sr_sum = sr_r_q + sr_bit_q;
	assign len    = sr_r_q[31:0];
	assign udvd_x = {1'b0, mx_q[30:0], 30'b0} + 62'(len >> 1);
	assign udvd_y = {1'b0, my_q[30:0], 30'b0} + 62'(len >> 1);

	assign rem_sh = {dv_rem_q[63:0], dv_num_q[95]};
	assign rem_ge = rem_sh >= {1'b0, dv_den_q};
	assign rem_nx = rem_ge ? rem_sh - {1'b0, dv_den_q} : rem_sh;

	assign uval = (cmd.op == OP_DIVY_GO ? sx_q : sy_q) ? -$signed(dv_quo_q[31:0])
		: $signed(dv_quo_q[31:0]);

	assign n_x = cmd.pt ? kx_q : jx_q;
	assign n_y = cmd.pt ? ky_q : jy_q;
	assign om  = UNIT_ONE - 34'(c_q);

	assign s_mag   = s_q[32] ? 33'(-s_q) : 33'(s_q);
	assign den_md  = {1'b0, s_mag, 30'b0};
	assign num_mag = num_q[63] ? 63'(-num_q) : num_q[62:0];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_SQ0:    begin mul_a = $signed({3'b0, mx_q[30:0]}); mul_b = mul_a; end
			OP_SQ1:    begin mul_a = $signed({3'b0, my_q[30:0]}); mul_b = mul_a; end
			OP_DOT0:   begin mul_a = 34'(n_x); mul_b = 34'(wx_q); end
			OP_DOT1:   begin mul_a = 34'(n_y); mul_b = 34'(wy_q); end
			OP_CROSS0: begin mul_a = 34'(n_y); mul_b = 34'(wx_q); end
			OP_CROSS1: begin mul_a = 34'(n_x); mul_b = 34'(wy_q); end
			OP_NUM0:   begin mul_a = cmd.axis ? 34'(n_y) : 34'(n_x); mul_b = 34'(s_q); end
			OP_NUM1:   begin mul_a = om; mul_b = cmd.axis ? 34'(n_x) : 34'(n_y); end
			OP_MD0: begin
				mul_a = $signed({3'b0, margin});
				mul_b = $signed({2'b0, num_mag[31:0]});
			end
			OP_MD1: begin
				mul_a = $signed({3'b0, margin});
				mul_b = $signed({3'b0, num_mag[62:32]});
			end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign mul_p  = mul_a * mul_b;
	assign prod_s = mul_p[63:0];

	assign qs      = (dv_quo_q > Q_CAP) ? Q_CAP[62:0] : dv_quo_q[62:0];
	assign uoff    = (num_q[63] != s_q[32]) ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
	assign b_ax    = cmd.axis ? b_y : b_x;
	assign sum     = 64'(b_ax) + uoff;
	assign res_val = (sum > SAT_HI) ? COORD_WIDTH'(SAT_HI)
		: ((sum < SAT_LO) ? COORD_WIDTH'(SAT_LO) : COORD_WIDTH'(sum));

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_ACCEPT: begin
				vert_x_q <= vertex_x;
				vert_y_q <= vertex_y;
			end
			OP_SHIFT: begin
				if (cmd.cnt == 2'd0) begin
					first_x_q <= vert_x_q;
					first_y_q <= vert_y_q;
				end
				if (cmd.cnt == 2'd1) begin
					second_x_q <= vert_x_q;
					second_y_q <= vert_y_q;
				end
				older_x_q <= newer_x_q;
				older_y_q <= newer_y_q;
				newer_x_q <= vert_x_q;
				newer_y_q <= vert_y_q;
			end
			OP_ULOAD: begin
				mx_q   <= ux_in[EW-1] ? MW'(-ux_in) : MW'(ux_in);
				my_q   <= uy_in[EW-1] ? MW'(-uy_in) : MW'(uy_in);
				sx_q   <= ux_in[EW-1];
				sy_q   <= uy_in[EW-1];
				zero_q <= (ux_in == '0) && (uy_in == '0);
			end
			OP_NORM: begin
				if (norm_hi) begin
					mx_q <= mx_q >> 1;
					my_q <= my_q >> 1;
				end else if (norm_lo) begin
					mx_q <= mx_q << 1;
					my_q <= my_q << 1;
				end
			end
			OP_SQ0: sq_q <= prod_s;
			OP_SQ1: sq_q <= sq_q + prod_s;
			OP_SQRT_GO: begin
				sr_n_q   <= sq_q;
				sr_r_q   <= '0;
				sr_bit_q <= 64'd1 << 62;
			end
			OP_SQRT: begin
				if (sr_n_q >= sr_sum) begin
					sr_n_q <= sr_n_q - sr_sum;
					sr_r_q <= (sr_r_q >> 1) + sr_bit_q;
				end else begin
					sr_r_q <= sr_r_q >> 1;
				end
				sr_bit_q <= sr_bit_q >> 2;
			end
			OP_DIVX_GO: begin
				dv_num_q <= {udvd_x, 34'b0};
				dv_den_q <= {32'b0, len};
				dv_rem_q <= '0;
				dv_quo_q <= '0;
			end
			OP_DIVY_GO: begin
				unique case (cmd.unit)
					UNIT_J:  jx_q <= uval;
					UNIT_K:  kx_q <= uval;
					default: wx_q <= uval;
				endcase
				dv_num_q <= {udvd_y, 34'b0};
				dv_den_q <= {32'b0, len};
				dv_rem_q <= '0;
				dv_quo_q <= '0;
			end
			OP_DIV: begin
				dv_rem_q <= rem_nx;
				dv_num_q <= dv_num_q << 1;
				dv_quo_q <= {dv_quo_q[94:0], rem_ge};
			end
			OP_USTORE: begin
				unique case (cmd.unit)
					UNIT_J:  jy_q <= uval;
					UNIT_K:  ky_q <= uval;
					default: wy_q <= uval;
				endcase
			end
			OP_DOT0, OP_CROSS0, OP_NUM0: dot_q <= prod_s;
			OP_DOT1:   c_q <= trunc30(dot_q + prod_s);
			OP_CROSS1: s_q <= trunc30(dot_q - prod_s);
			OP_NUM1:   num_q <= cmd.axis ? dot_q - prod_s : dot_q + prod_s;
			OP_MD0:    md_q <= 96'(prod_s);
			OP_MD1:    md_q <= md_q + (96'(prod_s) << 32);
			OP_MD2:    md_q <= md_q + 96'(den_md >> 1);
			OP_MD_GO: begin
				dv_num_q <= md_q;
				dv_den_q <= den_md;
				dv_rem_q <= '0;
				dv_quo_q <= '0;
			end
			OP_RES: begin
				if (cmd.axis) res_y_q <= res_val;
				else          res_x_q <= res_val;
			end
			OP_EMIT: begin
				out_x_q    <= cmd.deg ? '0 : res_x_q;
				out_y_q    <= cmd.deg ? '0 : res_y_q;
				out_deg_q  <= cmd.deg;
				out_last_q <= cmd.last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_DIVX_GO || cmd.op == OP_DIVY_GO) dv_cnt_q <= DIV_UNIT_STEPS;
			else if (cmd.op == OP_MD_GO)                      dv_cnt_q <= DIV_MD_STEPS;
			else if (cmd.op == OP_DIV && dv_cnt_q != '0)      dv_cnt_q <= dv_cnt_q - 7'd1;
			if (cmd.op == OP_EMIT)                out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)   out_valid_q <= 1'b0;
		end
	end

	assign sts.unit_zero = zero_q;
	assign sts.norm_done = !norm_hi && !norm_lo;
	assign sts.sqrt_done = (sr_bit_q == '0);
	assign sts.div_done  = (dv_cnt_q == '0);
	assign sts.s_zero    = (s_q == '0);
	assign sts.out_free  = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign point_x    = out_x_q;
	assign point_y    = out_y_q;
	assign degenerate = out_deg_q;
	assign last_point = out_last_q;

endmodule

@@ src/polygon_margin_offset.sv @@
// ----------------------------------------------------------------------------
// polygon_margin_offset
// Bevel-join margin offset of a closed polygon streamed one vertex per
// request, with an APB register for the margin distance.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  vertex   | in_valid / in_stall   | vertex_x, vertex_y, last_vertex
//  point    | out_valid / out_stall | point_x, point_y, degenerate, last_point
//  config   | psel/penable/pready   | paddr, pwdata, prdata (margin_distance)
//
//  First and second vertex: stored by the IDLE and SHIFT states, no corner is run.
//  Each corner is paced by the bit-per-cycle divider (62 steps per unit component,
//  96 per point coordinate) and the 32-step square root; the last vertex runs
//  three corners. Reset clears the controller, vertex count and output valid.
//  A stalled output holds the sequencer only when the next point is ready.
// ----------------------------------------------------------------------------
module polygon_margin_offset #(
	parameter int COORD_WIDTH = pmo_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = pmo_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pmo_pkg::PADDR_W-1:0]   paddr,
	input  logic [pmo_pkg::PDATA_W-1:0]   pwdata,
	output logic [pmo_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] vertex_x,
	input  logic signed [COORD_WIDTH-1:0] vertex_y,
	input  logic                          last_vertex,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0] point_x,
	output logic signed [COORD_WIDTH-1:0] point_y,
	output logic                          degenerate,
	output logic                          last_point
);
	import pmo_pkg::*;

	localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(64'd1 << FRAC_BITS);

	logic [MARGIN_W-1:0] margin_q;
	pmo_cmd_t cmd;
	pmo_sts_t sts;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MARGIN) ? PDATA_W'(margin_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= MARGIN_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_MARGIN) begin
			margin_q <= pwdata[MARGIN_W-1:0];
		end
	end

	pmo_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.last_vertex (last_vertex),
		.in_stall    (in_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	pmo_dpath #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.vertex_x   (vertex_x),
		.vertex_y   (vertex_y),
		.margin     (margin_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.point_x    (point_x),
		.point_y    (point_y),
		.degenerate (degenerate),
		.last_point (last_point)
	);

endmodule
